// ===== rtl/dip_pkg.sv =====
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types and constants for the double integer power block.
// ----------------------------------------------------------------------------
package dip_pkg;

   localparam int MAX_EXPONENT = 1024;
   localparam int CNT_W        = $clog2(MAX_EXPONENT + 1);

   localparam logic [63:0] ONE_BITS   = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] CANON_NAN  = 64'h7FF8_0000_0000_0000;
   localparam logic [10:0] EXP_ONES   = 11'h7FF;
   localparam int          QBITS      = 56;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MSTART,
      ST_MUL,
      ST_NORM,
      ST_ROUND,
      ST_DSTART,
      ST_DPRE,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

// ===== rtl/double_integer_power.sv =====
// ----------------------------------------------------------------------------
// double_integer_power
// Raises a binary64 base to a signed integer exponent by repeated multiply.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Exponent zero gives
// 1.0 straight away (with rsp_zero_to_zero set for a zero base) and a zero
// base gives +0.0; neither uses the multiplier. Otherwise one shared 27x27
// multiplier forms each rounded product over four passes, and each product
// then takes one normalising shift at a time before it is rounded. A negative
// exponent adds a bit-serial reciprocal, which is normalised and rounded in
// the same way. The result is shown for one cycle with rsp_valid and cannot
// be held off; busy is high from acceptance until that cycle.
// ----------------------------------------------------------------------------
module double_integer_power (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_base_bits,
   input  logic signed [11:0] req_exponent,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_bits,
   output logic        rsp_zero_to_zero
);

   dip_pkg::state_type state_ff, state_in;

   logic [63:0]  base_ff, base_in;
   logic [63:0]  acc_ff, acc_in;
   logic         neg_ff, neg_in;
   logic         div_ff, div_in;
   logic         flag_ff, flag_in;
   logic [dip_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [52:0]  ma_ff, ma_in;
   logic [52:0]  mb_ff, mb_in;
   logic [53:0]  pp_ff, pp_in;
   logic [105:0] p_ff, p_in;
   logic signed [13:0] e_ff, e_in;
   logic         sg_ff, sg_in;
   logic         stk_ff, stk_in;
   logic [2:0]   ph_ff, ph_in;
   logic [53:0]  r_ff, r_in;
   logic [5:0]   q_ff, q_in;
   logic         vld_ff, vld_in;
   logic [63:0]  res_ff, res_in;
   logic         z2z_ff, z2z_in;

   // request decode
   logic [11:0] mag;
   logic [16:0] mag_sat;
   logic        base_zero;

   // operand decode
   logic [10:0] a_x, b_x;
   logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
   logic [26:0] op_x, op_y;
   logic [105:0] pp_sh;

   // rounding
   logic        rnd_up;
   logic [53:0] m1;
   logic [52:0] m_r;
   logic signed [13:0] e_r;
   logic        ge;
   logic [53:0] r_sub;

   assign mag = req_exponent[11] ? 12'(-req_exponent) : 12'(req_exponent);
   assign mag_sat = ({5'd0, mag} > 17'(dip_pkg::MAX_EXPONENT)) ?
                    17'(dip_pkg::MAX_EXPONENT) : {5'd0, mag};
   assign base_zero = (req_base_bits[62:0] == 63'd0);

   assign a_x    = acc_ff[62:52];
   assign b_x    = base_ff[62:52];
   assign a_zero = (acc_ff[62:0] == 63'd0);
   assign b_zero = (base_ff[62:0] == 63'd0);
   assign a_inf  = (a_x == dip_pkg::EXP_ONES) && (acc_ff[51:0] == 52'd0);
   assign b_inf  = (b_x == dip_pkg::EXP_ONES) && (base_ff[51:0] == 52'd0);
   assign a_nan  = (a_x == dip_pkg::EXP_ONES) && (acc_ff[51:0] != 52'd0);
   assign b_nan  = (b_x == dip_pkg::EXP_ONES) && (base_ff[51:0] != 52'd0);

   always_comb begin
      case (ph_ff)
         3'd0:    begin op_x = ma_ff[26:0];         op_y = mb_ff[26:0];         end
         3'd1:    begin op_x = ma_ff[26:0];         op_y = {1'b0, mb_ff[52:27]}; end
         3'd2:    begin op_x = {1'b0, ma_ff[52:27]}; op_y = mb_ff[26:0];         end
         default: begin op_x = {1'b0, ma_ff[52:27]}; op_y = {1'b0, mb_ff[52:27]}; end
      endcase
   end

   always_comb begin
      case (ph_ff)
         3'd1:    pp_sh = {52'd0, pp_ff};
         3'd2:    pp_sh = {25'd0, pp_ff, 27'd0};
         3'd3:    pp_sh = {25'd0, pp_ff, 27'd0};
         default: pp_sh = {pp_ff[51:0], 54'd0};
      endcase
   end

   assign rnd_up = p_ff[52] & ((|p_ff[51:0]) | stk_ff | p_ff[53]);
   assign m1     = {1'b0, p_ff[105:53]} + 54'(rnd_up);
   assign m_r    = m1[53] ? m1[53:1] : m1[52:0];
   assign e_r    = m1[53] ? e_ff + 14'sd1 : e_ff;

   assign ge    = (r_ff >= {1'b0, ma_ff});
   assign r_sub = ge ? (r_ff - {1'b0, ma_ff}) : r_ff;

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      div_in   = div_ff;
      flag_in  = flag_ff;
      cnt_in   = cnt_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      pp_in    = pp_ff;
      p_in     = p_ff;
      e_in     = e_ff;
      sg_in    = sg_ff;
      stk_in   = stk_ff;
      ph_in    = ph_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      vld_in   = 1'b0;
      res_in   = res_ff;
      z2z_in   = z2z_ff;

      case (state_ff)
         dip_pkg::ST_IDLE: begin
            if (start) begin
               base_in = req_base_bits;
               neg_in  = req_exponent[11];
               div_in  = 1'b0;
               cnt_in  = dip_pkg::CNT_W'(mag_sat);
               flag_in = 1'b0;
               if (mag_sat == 17'd0) begin
                  acc_in   = dip_pkg::ONE_BITS;
                  flag_in  = base_zero;
                  state_in = dip_pkg::ST_FIN;
               end else if (base_zero) begin
                  acc_in   = 64'd0;
                  state_in = dip_pkg::ST_FIN;
               end else begin
                  acc_in   = dip_pkg::ONE_BITS;
                  state_in = dip_pkg::ST_MSTART;
               end
            end
         end

         dip_pkg::ST_MSTART: begin
            sg_in  = acc_ff[63] ^ base_ff[63];
            ma_in  = {(a_x != 11'd0), acc_ff[51:0]};
            mb_in  = {(b_x != 11'd0), base_ff[51:0]};
            e_in   = $signed({3'd0, ((a_x == 11'd0) ? 11'd1 : a_x)})
                   + $signed({3'd0, ((b_x == 11'd0) ? 11'd1 : b_x)}) - 14'sd1022;
            p_in   = 106'd0;
            stk_in = 1'b0;
            ph_in  = 3'd0;
            state_in = dip_pkg::ST_MUL;
            if (a_nan || b_nan || ((a_inf || b_inf) && (a_zero || b_zero))) begin
               acc_in = dip_pkg::CANON_NAN;
            end else if (a_inf || b_inf) begin
               acc_in = {acc_ff[63] ^ base_ff[63], dip_pkg::EXP_ONES, 52'd0};
            end else if (a_zero || b_zero) begin
               acc_in = {acc_ff[63] ^ base_ff[63], 63'd0};
            end
            if (a_nan || b_nan || a_inf || b_inf || a_zero || b_zero) begin
               cnt_in = cnt_ff - dip_pkg::CNT_W'(1);
               if (cnt_ff != dip_pkg::CNT_W'(1)) begin
                  state_in = dip_pkg::ST_MSTART;
               end else if (neg_ff) begin
                  state_in = dip_pkg::ST_DSTART;
               end else begin
                  state_in = dip_pkg::ST_FIN;
               end
            end
         end

         dip_pkg::ST_MUL: begin
            pp_in = op_x * op_y;
            if (ph_ff != 3'd0) begin
               p_in = p_ff + pp_sh;
            end
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd4) begin
               state_in = dip_pkg::ST_NORM;
            end
         end

         dip_pkg::ST_NORM: begin
            if (e_ff < -14'sd120) begin
               p_in   = 106'd0;
               stk_in = 1'b1;
               e_in   = 14'sd1;
            end else if (e_ff < 14'sd1) begin
               stk_in = stk_ff | p_ff[0];
               p_in   = {1'b0, p_ff[105:1]};
               e_in   = e_ff + 14'sd1;
            end else if (!p_ff[105] && (e_ff > 14'sd1) && (p_ff != 106'd0)) begin
               p_in = {p_ff[104:0], 1'b0};
               e_in = e_ff - 14'sd1;
            end else begin
               state_in = dip_pkg::ST_ROUND;
            end
         end

         dip_pkg::ST_ROUND: begin
            if (e_r >= 14'sd2047) begin
               acc_in = {sg_ff, dip_pkg::EXP_ONES, 52'd0};
            end else begin
               acc_in = {sg_ff, (m_r[52] ? e_r[10:0] : 11'd0), m_r[51:0]};
            end
            if (div_ff) begin
               state_in = dip_pkg::ST_FIN;
            end else begin
               cnt_in = cnt_ff - dip_pkg::CNT_W'(1);
               if (cnt_ff != dip_pkg::CNT_W'(1)) begin
                  state_in = dip_pkg::ST_MSTART;
               end else if (neg_ff) begin
                  state_in = dip_pkg::ST_DSTART;
               end else begin
                  state_in = dip_pkg::ST_FIN;
               end
            end
         end

         dip_pkg::ST_DSTART: begin
            div_in = 1'b1;
            sg_in  = acc_ff[63];
            ma_in  = {(a_x != 11'd0), acc_ff[51:0]};
            e_in   = 14'sd2046 - $signed({3'd0, ((a_x == 11'd0) ? 11'd1 : a_x)});
            p_in   = 106'd0;
            stk_in = 1'b0;
            q_in   = 6'd0;
            r_in   = 54'd1 << 52;
            if (a_nan) begin
               acc_in   = dip_pkg::CANON_NAN;
               state_in = dip_pkg::ST_FIN;
            end else if (a_inf) begin
               acc_in   = {acc_ff[63], 63'd0};
               state_in = dip_pkg::ST_FIN;
            end else if (a_zero) begin
               acc_in   = {acc_ff[63], dip_pkg::EXP_ONES, 52'd0};
               state_in = dip_pkg::ST_FIN;
            end else begin
               state_in = dip_pkg::ST_DPRE;
            end
         end

         dip_pkg::ST_DPRE: begin
            if (!ma_ff[52]) begin
               ma_in = {ma_ff[51:0], 1'b0};
               e_in  = e_ff + 14'sd1;
            end else begin
               state_in = dip_pkg::ST_DIV;
            end
         end

         dip_pkg::ST_DIV: begin
            r_in = {r_sub[52:0], 1'b0};
            q_in = q_ff + 6'd1;
            if (q_ff == 6'(dip_pkg::QBITS - 1)) begin
               p_in     = {p_ff[54:0], ge, 50'd0};
               stk_in   = (r_sub != 54'd0);
               state_in = dip_pkg::ST_NORM;
            end else begin
               p_in = {p_ff[104:0], ge};
            end
         end

         dip_pkg::ST_FIN: begin
            vld_in   = 1'b1;
            res_in   = acc_ff;
            z2z_in   = flag_ff;
            state_in = dip_pkg::ST_IDLE;
         end

         default: begin
            state_in = dip_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dip_pkg::ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      div_ff  <= div_in;
      flag_ff <= flag_in;
      cnt_ff  <= cnt_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      pp_ff   <= pp_in;
      p_ff    <= p_in;
      e_ff    <= e_in;
      sg_ff   <= sg_in;
      stk_ff  <= stk_in;
      ph_ff   <= ph_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
      z2z_ff  <= z2z_in;
   end

   assign busy             = (state_ff != dip_pkg::ST_IDLE);
   assign rsp_valid        = vld_ff;
   assign rsp_result_bits  = res_ff;
   assign rsp_zero_to_zero = z2z_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   a_z2z_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_to_zero) |-> (rsp_result_bits == dip_pkg::ONE_BITS))
      else $error("zero to zero without 1.0");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but not busy");

   a_fin_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dip_pkg::ST_FIN) |=> rsp_valid)
      else $error("finish without response");

endmodule

// ===== tb/double_integer_power_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_integer_power_tb
// Checks the integer power block against a predictor built on the
// simulator's binary64 arithmetic.
// ----------------------------------------------------------------------------
// Requests go from a queue to a clocked driver with random start gaps; a
// clocked monitor compares each strobed result with the oldest predicted one.
// ----------------------------------------------------------------------------
module double_integer_power_tb;

   localparam int WATCHDOG_LIMIT = 400000;

   typedef struct {
      logic [63:0]        base;
      logic signed [11:0] expo;
      bit                 drain;
   } pow_request_type;

   typedef struct {
      logic [63:0] bits;
      logic        zero_flag;
   } pow_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_base_bits;
   logic signed [11:0] req_exponent;
   logic        rsp_valid;
   logic [63:0] rsp_result_bits;
   logic        rsp_zero_to_zero;

   pow_request_type pending_requests[$];
   pow_result_type  predicted_results[$];
   int              gap_left;
   int              quiet_cycles;
   bit              failed;

   double_integer_power dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_base_bits(req_base_bits),
      .req_exponent(req_exponent),
      .rsp_valid(rsp_valid),
      .rsp_result_bits(rsp_result_bits),
      .rsp_zero_to_zero(rsp_zero_to_zero)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic pow_result_type predict_power(logic [63:0] base,
                                                    logic signed [11:0] expo);
      pow_result_type r;
      int             mag;
      real            acc;
      real            b;
      bit             base_zero;
      bit             neg;
      neg       = expo[11];
      mag       = neg ? -int'(expo) : int'(expo);
      if (mag > dip_pkg::MAX_EXPONENT) mag = dip_pkg::MAX_EXPONENT;
      base_zero = (base[62:0] == 63'd0);
      b         = $bitstoreal(base);
      r.zero_flag = 1'b0;
      if (mag == 0) begin
         r.zero_flag = base_zero;
         acc = 1.0;
      end else if (base_zero) begin
         acc = 0.0;
      end else begin
         acc = 1.0;
         for (int i = 0; i < mag; i++) acc = acc * b;
         if (neg) acc = 1.0 / acc;
      end
      r.bits = $realtobits(acc);
      if (r.bits[62:52] == dip_pkg::EXP_ONES && r.bits[51:0] != 52'd0)
         r.bits = dip_pkg::CANON_NAN;
      return r;
   endfunction

   function automatic logic [63:0] random_base();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v[62:52] = 11'(11'h3FE + $urandom_range(0, 1));
         4, 5:       v[62:52] = 11'(11'h3F0 + $urandom_range(0, 31));
         6:          v[62:52] = 11'h000;
         7:          v[62:52] = dip_pkg::EXP_ONES;
         8:          v[62:0]  = $urandom_range(0, 1) ? 63'd0 : v[62:0];
         default:    ;
      endcase
      return v;
   endfunction

   function automatic logic signed [11:0] random_exponent();
      if ($urandom_range(0, 60) == 0) return 12'($urandom);
      if ($urandom_range(0, 9) == 0) return 12'($urandom_range(0, 0) - $urandom_range(0, 200));
      return 12'(int'($urandom_range(0, 60)) - 30);
   endfunction

   task automatic add_request(logic [63:0] base, int expo, bit drain = 1'b0);
      pow_request_type q;
      q.base  = base;
      q.expo  = 12'(expo);
      q.drain = drain;
      pending_requests.push_back(q);
   endtask

   // driver
   always @(posedge clock) begin
      bit             go;
      pow_result_type p;
      if (reset) begin
         start         <= 1'b0;
         req_base_bits <= '0;
         req_exponent  <= '0;
         gap_left      <= 0;
      end else begin
         go = 1'b0;
         if (start && !busy) begin
            p = predict_power(req_base_bits, req_exponent);
            predicted_results.push_back(p);
            if ($urandom_range(0, 3) == 0 && pending_requests.size() > 60)
               gap_left <= $urandom_range(1, 18);
         end
         if (start && busy) begin
            go = 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_requests.size() > 0) begin
            if (!(pending_requests[0].drain &&
                  (predicted_results.size() > 0 || busy))) begin
               go            = 1'b1;
               req_base_bits <= pending_requests[0].base;
               req_exponent  <= pending_requests[0].expo;
               void'(pending_requests.pop_front());
            end
         end
         start <= go;
      end
   end

   // monitor
   always @(posedge clock) begin
      pow_result_type e;
      if (!reset && rsp_valid) begin
         if (predicted_results.size() == 0) begin
            $display("%0t: unexpected result %h flag %b", $time, rsp_result_bits,
                     rsp_zero_to_zero);
            failed <= 1'b1;
         end else begin
            e = predicted_results.pop_front();
            if (rsp_result_bits !== e.bits) begin
               $display("%0t: result_bits expected %h actual %h", $time, e.bits,
                        rsp_result_bits);
               failed <= 1'b1;
            end
            if (rsp_zero_to_zero !== e.zero_flag) begin
               $display("%0t: zero_to_zero expected %b actual %b", $time, e.zero_flag,
                        rsp_zero_to_zero);
               failed <= 1'b1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("double_integer_power regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int guard;
      failed        = 1'b0;
      quiet_cycles  = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_base_bits = '0;
      req_exponent  = '0;
      gap_left      = 0;

      add_request(dip_pkg::ONE_BITS, 0);
      add_request(64'h0, 0);
      add_request(64'h8000_0000_0000_0000, 0);
      add_request(dip_pkg::CANON_NAN, 0);
      add_request(64'h7FF0_0000_0000_0000, 3);
      add_request(64'hFFF0_0000_0000_0000, 3);
      add_request(64'hFFF0_0000_0000_0000, -3);
      add_request(64'h7FF4_0000_0000_1234, 5);
      add_request(64'h0, -5);
      add_request(64'h8000_0000_0000_0000, 7);
      add_request(64'h4000_0000_0000_0000, 1024);
      add_request(64'h4000_0000_0000_0000, -1024);
      add_request(64'h3FF8_0000_0000_0000, 2047);
      add_request(64'h3FE0_0000_0000_0000, -2048);
      add_request(64'h0000_0000_0000_0001, 2);
      add_request(64'h0000_0000_0000_0001, -1);
      add_request(64'hBFF0_0000_0000_0000, -1);
      add_request(64'h7FEF_FFFF_FFFF_FFFF, 2);
      add_request(64'h4008_0000_0000_0000, -1);
      add_request(64'h3FF1_9999_9999_999A, 10);
      add_request(64'hFFFF_FFFF_FFFF_FFFF, -1);
      add_request(64'hC000_0000_0000_0000, 1);
      add_request(64'h000F_FFFF_FFFF_FFFF, -2, 1'b1);
      for (int i = 0; i < 520; i++)
         add_request(random_base(), int'(random_exponent()), (i % 173) == 172);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (pending_requests.size() == 0);
      @(posedge clock);
      while (start || predicted_results.size() > 0) @(posedge clock);
      guard = 0;
      while (guard < 20) begin
         @(posedge clock);
         guard++;
      end
      if (!failed) begin
         $display("double_integer_power regression: pass");
      end else begin
         $display("double_integer_power regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dip_pkg.sv
rtl/double_integer_power.sv
tb/double_integer_power_tb.sv
